### rtl/accel_fall_detector_unit_macros.svh
// assertion macros for the accelerometer fall detector
// used by the top level only, no other dependencies
`ifndef ACCEL_FALL_DETECTOR_UNIT_MACROS_SVH
`define ACCEL_FALL_DETECTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising clock edge out of reset
`define AFD_ASSERT_IMPL(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("fall detector check failed");
// next-cycle implication
`define AFD_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("fall detector check failed");
`else
`define AFD_ASSERT_IMPL(lbl, clk_i, rst_n_i, ante, cons)
`define AFD_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons)
`endif
`endif

### rtl/afd_pkg.sv
// shared types and constants of the accelerometer fall detector
// no dependencies
package afd_pkg;

	localparam int AXIS_BITS = 16;
	localparam int SQ_W      = 2 * AXIS_BITS;
	localparam int MAG_W     = 32;
	// sum of three squares needs two more bits; keep at least one above the magnitude
	localparam int SUM_W     = (SQ_W + 2 > MAG_W + 1) ? SQ_W + 2 : MAG_W + 1;
	localparam int TIME_W    = 32;
	localparam int WIN_W     = 16;
	localparam int CNT_W     = 8;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam logic [MAG_W-1:0] THRESH_RESET   = 32'd69739201;
	localparam logic [WIN_W-1:0] INTERVAL_RESET = 16'd20;
	localparam logic [CNT_W-1:0] EVENTS_RESET   = 8'd2;
	localparam logic [WIN_W-1:0] QUIET_RESET    = 16'd1500;

	typedef enum logic [1:0] {
		REG_THRESH   = 2'd0,
		REG_INTERVAL = 2'd1,
		REG_EVENTS   = 2'd2,
		REG_QUIET    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [MAG_W-1:0] rise_threshold_sq;
		logic [WIN_W-1:0] max_rise_interval_ms;
		logic [CNT_W-1:0] events_needed;
		logic [WIN_W-1:0] quiet_window_ms;
	} cfg_t;

endpackage

### rtl/afd_cfg_regs.sv
// apb configuration registers of the fall detector
// depends on afd_pkg
module afd_cfg_regs import afd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_threshold_sq    <= THRESH_RESET;
			cfg_q.max_rise_interval_ms <= INTERVAL_RESET;
			cfg_q.events_needed        <= EVENTS_RESET;
			cfg_q.quiet_window_ms      <= QUIET_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_THRESH:   cfg_q.rise_threshold_sq    <= pwdata[MAG_W-1:0];
				REG_INTERVAL: cfg_q.max_rise_interval_ms <= pwdata[WIN_W-1:0];
				REG_EVENTS:   cfg_q.events_needed        <= pwdata[CNT_W-1:0];
				REG_QUIET:    cfg_q.quiet_window_ms      <= pwdata[WIN_W-1:0];
				default:      cfg_q                      <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_THRESH:   prdata = DATA_W'(cfg_q.rise_threshold_sq);
			REG_INTERVAL: prdata = DATA_W'(cfg_q.max_rise_interval_ms);
			REG_EVENTS:   prdata = DATA_W'(cfg_q.events_needed);
			REG_QUIET:    prdata = DATA_W'(cfg_q.quiet_window_ms);
			default:      prdata = '0;
		endcase
	end

endmodule

### rtl/afd_axis_lane.sv
// one axis lane: absolute value and square, registered
// depends on afd_pkg
module afd_axis_lane import afd_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [AXIS_BITS-1:0] axis,
	output logic        [SQ_W-1:0]      sq_s1
);

	logic [AXIS_BITS-1:0] raw;
	logic [AXIS_BITS-1:0] mag;

	assign raw = axis;
	// most negative value maps to its own magnitude as unsigned
	assign mag = raw[AXIS_BITS-1] ? (~raw + AXIS_BITS'(1)) : raw;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= SQ_W'(mag) * SQ_W'(mag);
		end
	end

endmodule

### rtl/afd_merge.sv
// merge stage: sums the lane squares, compares, runs the event counter
// depends on afd_pkg
module afd_merge import afd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [SQ_W-1:0]   sq_x,
	input  logic [SQ_W-1:0]   sq_y,
	input  logic [SQ_W-1:0]   sq_z,
	input  logic [TIME_W-1:0] time_s1,
	input  cfg_t              cfg,
	output logic              fall_s2,
	output logic              above_s2,
	output logic [MAG_W-1:0]  mag_s2,
	output logic [CNT_W-1:0]  count_s2
);

	logic [SUM_W-1:0]  sum;
	logic [MAG_W-1:0]  mag;
	logic              above;
	logic              quiet;
	logic              rise;
	logic              in_interval;
	logic              counted;
	logic              fall;
	logic [CNT_W-1:0]  cnt_base;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_new;
	logic [TIME_W-1:0] since_event;
	logic [TIME_W-1:0] since_rise;

	logic              above_flag_q;
	logic [TIME_W-1:0] last_rise_q;
	logic [TIME_W-1:0] last_event_q;
	logic [CNT_W-1:0]  count_q;

	assign sum   = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
	assign mag   = (|sum[SUM_W-1:MAG_W]) ? '1 : sum[MAG_W-1:0];
	assign above = mag >= cfg.rise_threshold_sq;

	// quiet window test comes before counting
	assign since_event = time_s1 - last_event_q;
	assign quiet       = since_event >= TIME_W'(cfg.quiet_window_ms);
	assign cnt_base    = quiet ? '0 : count_q;

	assign rise        = above && !above_flag_q;
	assign since_rise  = time_s1 - last_rise_q;
	assign in_interval = since_rise <= TIME_W'(cfg.max_rise_interval_ms);
	assign counted     = rise && in_interval;
	assign cnt_inc     = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + CNT_W'(1);
	assign fall        = counted && (cnt_inc >= cfg.events_needed);
	assign cnt_new     = counted ? (fall ? '0 : cnt_inc) : cnt_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_flag_q <= 1'b0;
			last_rise_q  <= '0;
			last_event_q <= '0;
			count_q      <= '0;
		end else if (take) begin
			above_flag_q <= above;
			count_q      <= cnt_new;
			if (rise) begin
				last_rise_q <= time_s1;
			end
			if (counted && !fall) begin
				last_event_q <= time_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fall_s2  <= fall;
			above_s2 <= above;
			mag_s2   <= mag;
			count_s2 <= cnt_new;
		end
	end

endmodule

### rtl/accel_fall_detector_unit.sv
// top level of the accelerometer fall detector
// depends on afd_pkg, afd_cfg_regs, afd_axis_lane, afd_merge and the macro header
`include "accel_fall_detector_unit_macros.svh"

// Takes one three-axis sample per clock unless stalled and returns one result
// transaction per sample, in order, via stage 1 and the output register. Three
// axis lanes square x, y and z side by side into stage-1 registers; the merge
// stage adds them (saturating at 2^32-1), compares with the squared threshold
// and runs the rising-edge interval test, the event counter and the quiet window,
// all combinationally, which is what holds the rate at one sample per cycle. The
// result sits in an output register, so a new sample is taken while a finished
// result waits; the sample side stalls only when both stages are full and the
// result side stalls. Registers: 0x0 squared threshold, 0x4 max rise interval
// in ms, 0x8 events for a fall, 0xC quiet window in ms; write them only while idle.
module accel_fall_detector_unit import afd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample channel
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic signed [AXIS_BITS-1:0] accel_x,
	input  logic signed [AXIS_BITS-1:0] accel_y,
	input  logic signed [AXIS_BITS-1:0] accel_z,
	input  logic        [TIME_W-1:0]    time_ms,
	// result channel
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        fall_flag,
	output logic                        above_threshold,
	output logic        [MAG_W-1:0]     magnitude_sq,
	output logic        [CNT_W-1:0]     event_count,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic        [ADDR_W-1:0]    paddr,
	input  logic        [DATA_W-1:0]    pwdata,
	output logic        [DATA_W-1:0]    prdata,
	output logic                        pready
);

	cfg_t              cfg;
	logic              valid_s1;
	logic [TIME_W-1:0] time_s1;
	logic [SQ_W-1:0]   sq_x_s1;
	logic [SQ_W-1:0]   sq_y_s1;
	logic [SQ_W-1:0]   sq_z_s1;
	logic              adv_s1;
	logic              adv_s2;
	logic              accept;
	logic              take;

	// output register frees up when empty or when its transaction leaves
	assign adv_s2       = !result_valid || !result_stall;
	// stage 1 frees up when empty or when it moves into the output register
	assign adv_s1       = !valid_s1 || adv_s2;
	assign sample_stall = !adv_s1;
	assign accept       = sample_valid && adv_s1;
	assign take         = valid_s1 && adv_s2;

	afd_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// one lane per axis
	afd_axis_lane u_lane_x (
		.clk   (clk),
		.en    (accept),
		.axis  (accel_x),
		.sq_s1 (sq_x_s1)
	);

	afd_axis_lane u_lane_y (
		.clk   (clk),
		.en    (accept),
		.axis  (accel_y),
		.sq_s1 (sq_y_s1)
	);

	afd_axis_lane u_lane_z (
		.clk   (clk),
		.en    (accept),
		.axis  (accel_z),
		.sq_s1 (sq_z_s1)
	);

	// timestamp travels alongside the squares
	always_ff @(posedge clk) begin
		if (accept) begin
			time_s1 <= time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= sample_valid;
			end
			if (adv_s2) begin
				result_valid <= valid_s1;
			end
		end
	end

	// sum, threshold compare and event state, loaded into the output register
	afd_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.sq_x     (sq_x_s1),
		.sq_y     (sq_y_s1),
		.sq_z     (sq_z_s1),
		.time_s1  (time_s1),
		.cfg      (cfg),
		.fall_s2  (fall_flag),
		.above_s2 (above_threshold),
		.mag_s2   (magnitude_sq),
		.count_s2 (event_count)
	);

	// the sample side is held back only while stage 1 holds a transaction
	`AFD_ASSERT_IMPL(a_stall_needs_s1, clk, arst_n, sample_stall, valid_s1)
	// an accepted sample always lands in stage 1
	`AFD_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, sample_valid && !sample_stall, valid_s1)
	// a fall comes only from a sample above the threshold
	`AFD_ASSERT_IMPL(a_fall_above, clk, arst_n, result_valid && fall_flag, above_threshold)
	// a flagged fall clears the event count
	`AFD_ASSERT_IMPL(a_fall_clears, clk, arst_n, result_valid && fall_flag, event_count == '0)

endmodule

### tb/afd_checker.sv
// checker for the accelerometer fall detector: watches the sample, result and register ports,
// predicts each result and compares it field by field
// depends on afd_pkg
module afd_checker import afd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	input  logic                        sample_stall,
	input  logic signed [AXIS_BITS-1:0] accel_x,
	input  logic signed [AXIS_BITS-1:0] accel_y,
	input  logic signed [AXIS_BITS-1:0] accel_z,
	input  logic        [TIME_W-1:0]    time_ms,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  logic                        fall_flag,
	input  logic                        above_threshold,
	input  logic        [MAG_W-1:0]     magnitude_sq,
	input  logic        [CNT_W-1:0]     event_count,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic        [ADDR_W-1:0]    paddr,
	input  logic        [DATA_W-1:0]    pwdata,
	output int                          fails,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             fall;
		logic             above;
		logic [MAG_W-1:0] mag_sq;
		logic [CNT_W-1:0] count;
	} fall_verdict_t;

	cfg_t                cfg;
	logic                was_above;
	logic [TIME_W-1:0]   last_rise_ms;
	logic [TIME_W-1:0]   last_event_ms;
	logic [CNT_W-1:0]    event_tally;
	fall_verdict_t       verdict_q[$];
	fall_verdict_t       want;
	int                  mismatches;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned exp_val);
		mismatches++;
		$display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, exp_val);
	endtask

	function automatic longint unsigned axis_energy(input logic signed [AXIS_BITS-1:0] v);
		longint a;
		a = v;
		if (a < 0)
			a = -a;
		return a * a;
	endfunction

	// one step of the detector on the mirrored state
	function automatic fall_verdict_t judge_sample(input logic signed [AXIS_BITS-1:0] x,
			input logic signed [AXIS_BITS-1:0] y, input logic signed [AXIS_BITS-1:0] z,
			input logic [TIME_W-1:0] t);
		fall_verdict_t     v;
		longint unsigned   energy;
		logic [TIME_W-1:0] gap;
		energy = axis_energy(x) + axis_energy(y) + axis_energy(z);
		v.mag_sq = (energy > 64'hFFFF_FFFF) ? '1 : energy[MAG_W-1:0];
		v.above = v.mag_sq >= cfg.rise_threshold_sq;
		v.fall = 1'b0;
		// quiet window runs first, wrapping time
		gap = t - last_event_ms;
		if (gap >= cfg.quiet_window_ms)
			event_tally = '0;
		if (v.above) begin
			if (!was_above) begin
				gap = t - last_rise_ms;
				was_above = 1'b1;
				last_rise_ms = t;
				if (gap <= cfg.max_rise_interval_ms) begin
					if (event_tally != COUNT_MAX)
						event_tally++;
					if (event_tally >= cfg.events_needed) begin
						event_tally = '0;
						v.fall = 1'b1;
					end else begin
						last_event_ms = t;
					end
				end
			end
		end else begin
			was_above = 1'b0;
		end
		v.count = event_tally;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{rise_threshold_sq: THRESH_RESET, max_rise_interval_ms: INTERVAL_RESET,
				events_needed: EVENTS_RESET, quiet_window_ms: QUIET_RESET};
			was_above = 1'b0;
			last_rise_ms = '0;
			last_event_ms = '0;
			event_tally = '0;
			verdict_q.delete();
			mismatches = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected result", magnitude_sq, 0);
				end else begin
					want = verdict_q.pop_front();
					if (fall_flag !== want.fall)
						report_mismatch("fall_flag", fall_flag, want.fall);
					if (above_threshold !== want.above)
						report_mismatch("above_threshold", above_threshold, want.above);
					if (magnitude_sq !== want.mag_sq)
						report_mismatch("magnitude_sq", magnitude_sq, want.mag_sq);
					if (event_count !== want.count)
						report_mismatch("event_count", event_count, want.count);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_THRESH:   cfg.rise_threshold_sq    = pwdata[MAG_W-1:0];
					REG_INTERVAL: cfg.max_rise_interval_ms = pwdata[WIN_W-1:0];
					REG_EVENTS:   cfg.events_needed        = pwdata[CNT_W-1:0];
					REG_QUIET:    cfg.quiet_window_ms      = pwdata[WIN_W-1:0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall)
				verdict_q.push_back(judge_sample(accel_x, accel_y, accel_z, time_ms));
		end
		fails <= mismatches;
		pending <= verdict_q.size();
	end

endmodule

### tb/tb.sv
// top of the fall detector testbench: clock, reset, register writes, sample stimulus,
// result-side stalls and the verdict
// depends on afd_pkg, accel_fall_detector_unit and afd_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import afd_pkg::*;

	// cycles without any transaction before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// length of the long result-side hold-off
	localparam int HOLD_CYCLES = 80;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        sample_valid = 1'b0;
	logic                        sample_stall;
	logic signed [AXIS_BITS-1:0] accel_x = '0;
	logic signed [AXIS_BITS-1:0] accel_y = '0;
	logic signed [AXIS_BITS-1:0] accel_z = '0;
	logic        [TIME_W-1:0]    time_ms = '0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	logic                        fall_flag;
	logic                        above_threshold;
	logic        [MAG_W-1:0]     magnitude_sq;
	logic        [CNT_W-1:0]     event_count;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic        [ADDR_W-1:0]    paddr = '0;
	logic        [DATA_W-1:0]    pwdata = '0;
	logic        [DATA_W-1:0]    prdata;
	logic                        pready;

	int fails;
	int pending;

	// idle and stall chances in percent, rotated by the stimulus
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// bumped by the stimulus to ask the result side for one long hold-off
	int hold_asked = 0;
	// transactions offered so far by the random part, drives the idle and stall rotation
	int offered = 0;

	// stimulus-side copy of the settings, only used to shape timestamps and magnitudes
	logic [MAG_W-1:0]  cur_thresh = THRESH_RESET;
	logic [WIN_W-1:0]  win_interval = INTERVAL_RESET;
	logic [WIN_W-1:0]  win_quiet = QUIET_RESET;
	// running sample timestamp
	logic [TIME_W-1:0] clock_ms = '0;

	accel_fall_detector_unit i_dut (.*);

	afd_checker i_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// result side: random stalls, plus a long hold-off whenever one is asked for
	initial begin
		int served;
		served = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (served < hold_asked) begin
				served++;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// hang detection: any accepted transaction or register access restarts the count
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || psel || (sample_valid && !sample_stall) ||
					(result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// one register write, setup then access; psel stays up so writes can go back to back
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// writes all four registers; only called with no transaction in flight
	task automatic set_config(input logic [MAG_W-1:0] thr, input logic [WIN_W-1:0] ivl,
			input logic [CNT_W-1:0] evn, input logic [WIN_W-1:0] qw);
		write_reg(REG_THRESH, thr);
		write_reg(REG_INTERVAL, DATA_W'(ivl));
		write_reg(REG_EVENTS, DATA_W'(evn));
		write_reg(REG_QUIET, DATA_W'(qw));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_thresh = thr;
		win_interval = ivl;
		win_quiet = qw;
	endtask

	// offers one sample and returns at the edge where it is taken; valid stays high so the
	// next call can keep streaming
	task automatic send_sample(input logic signed [AXIS_BITS-1:0] x,
			input logic signed [AXIS_BITS-1:0] y, input logic signed [AXIS_BITS-1:0] z,
			input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		time_ms <= t;
		do @(posedge clk); while (sample_stall);
	endtask

	// stops offering and waits until every predicted result has come back
	task automatic drain_results();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// random motion: loud and quiet samples, full-scale corners and samples near the
	// threshold; with alternate set it is a clean loud/quiet train with short time steps
	task automatic offer_motion(input int n, input bit alternate);
		logic signed [AXIS_BITS-1:0] ax [3];
		int kind;
		int root;
		for (int i = 0; i < n; i++) begin
			case ((offered / 40) % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 56;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 56;
				end
				default: begin
					send_idle_pct = 6;
					recv_stall_pct = 6;
				end
			endcase
			offered++;
			kind = alternate ? ((i % 2) ? 0 : 4) : $urandom_range(0, 9);
			root = int'($floor($sqrt(real'(cur_thresh) / 3.0))) + int'($urandom_range(0, 2)) - 1;
			if (root < 0)
				root = 0;
			for (int k = 0; k < 3; k++) begin
				if (kind <= 3) begin
					// loud, any bit pattern
					ax[k] = AXIS_BITS'($urandom);
				end else if (kind <= 6) begin
					// quiet, a few lsb around zero
					ax[k] = AXIS_BITS'($urandom_range(0, 20) - 10);
				end else if (kind == 7) begin
					case ($urandom_range(3))
						0: ax[k] = {1'b1, {(AXIS_BITS-1){1'b0}}};
						1: ax[k] = {1'b0, {(AXIS_BITS-1){1'b1}}};
						2: ax[k] = '0;
						default: ax[k] = '1;
					endcase
				end else begin
					// magnitude close to the threshold, both signs
					if (root >= (1 << (AXIS_BITS - 1)))
						ax[k] = {1'b1, {(AXIS_BITS-1){1'b0}}};
					else
						ax[k] = AXIS_BITS'($urandom_range(1) ? -root : root);
				end
			end
			if (alternate) begin
				clock_ms += $urandom_range(0, 20);
			end else begin
				case ($urandom_range(0, 9))
					// arbitrary jump, reaches every timestamp bit and wraps
					0: clock_ms += $urandom;
					// step right around the quiet window
					1: clock_ms += win_quiet + $urandom_range(0, 2) - 1;
					default: clock_ms += $urandom_range(0, win_interval / 2 + 1);
				endcase
			end
			send_sample(ax[0], ax[1], ax[2], clock_ms);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: first rise measured from time zero with zero interval,
		// full-scale axes, threshold hit exactly, too-long interval, quiet-window clear,
		// timestamp wrap
		send_sample(-32768, -32768, -32768, 0);
		send_sample(32767, 32767, 32767, 5);
		send_sample(0, 0, 0, 10);
		send_sample(-32768, 0, 0, 15);
		send_sample(0, 0, 0, 16);
		send_sample(8351, 0, 0, 30);
		send_sample(0, 8350, 0, 31);
		send_sample(0, -8351, 0, 55);
		send_sample(-1, -1, -1, 3000);
		send_sample(0, 0, 0, 32'hFFFF_FFF0);
		send_sample(0, 0, 32767, 32'hFFFF_FFF5);
		send_sample(1, -1, 1, 32'hFFFF_FFFA);
		send_sample(-32768, 32767, 0, 5);
		send_sample(0, 0, 0, 32'hFFFF_FFFF);
		send_sample(21845, -21846, 0, 32'hAAAA_AAAA);
		clock_ms = 32'hAAAA_AAAA;
		offer_motion(60, 1'b0);
		drain_results();

		// lowest settings: zero interval, zero events needed, quiet window zero
		set_config(1, 0, 0, 0);
		send_sample(0, 0, 0, 200);
		send_sample(1, 0, 0, 200);
		send_sample(0, 0, 0, 200);
		send_sample(0, 1, 0, 200);
		send_sample(0, 0, -1, 200);
		clock_ms = 200;
		offer_motion(30, 1'b0);
		drain_results();

		// zero threshold keeps every sample above, widest windows, one event per fall
		set_config(0, 16'hFFFF, 1, 16'hFFFF);
		offer_motion(30, 1'b0);
		drain_results();

		// top threshold, only full-scale samples reach it
		set_config(32'd3221225472, WIN_W'($urandom_range(1, 500)),
			CNT_W'($urandom_range(1, 4)), WIN_W'($urandom_range(1, 3000)));
		offer_motion(60, 1'b0);
		drain_results();

		// mid settings with back pressure: the result side holds off while samples keep
		// coming so the pipeline fills, then the sample side pauses until all are back
		set_config($urandom_range(1000000, 2000000000), WIN_W'($urandom_range(5, 100)),
			CNT_W'($urandom_range(2, 6)), WIN_W'($urandom_range(100, 2000)));
		offer_motion(40, 1'b0);
		hold_asked++;
		offer_motion(30, 1'b0);
		drain_results();
		offer_motion(30, 1'b0);
		drain_results();

		// long clean train so the event count climbs high and reaches a large requirement
		set_config(1000, 16'hFFFF, 8'd140, 16'hFFFF);
		offer_motion(300, 1'b1);
		drain_results();

		// pipeline is two stages deep, leave room for anything stray
		repeat (10) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/afd_pkg.sv
rtl/afd_cfg_regs.sv
rtl/afd_axis_lane.sv
rtl/afd_merge.sv
rtl/accel_fall_detector_unit.sv
tb/afd_checker.sv
tb/tb.sv
